[rtl/core/scov_pkg.sv]
`timescale 1ns / 1ps
package scov_pkg;

    localparam int MAX_MOVES          = 4;
    localparam int ANGLE_BITS         = 16;
    localparam int TRIG_TABLE_ENTRIES = 1024;
    localparam int RANGE_BITS         = 16;

    localparam int CFG_BITS    = 16;
    localparam int COUNT_BITS  = 3;
    localparam int MOVE_REGS   = 4;
    localparam int NUM_MOVES   = (MAX_MOVES < MOVE_REGS) ? MAX_MOVES : MOVE_REGS;
    localparam int MM_BITS     = 16;

    localparam int IDX_BITS    = $clog2(TRIG_TABLE_ENTRIES);
    localparam int QUARTER     = TRIG_TABLE_ENTRIES / 4;
    localparam int QTR_BITS    = IDX_BITS - 2;
    localparam int MAG_BITS    = 15;
    localparam int FRAC_BITS   = 14;
    localparam int PROD_BITS   = RANGE_BITS + MAG_BITS;
    localparam int RND_BITS    = PROD_BITS + 1 - FRAC_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_BITS    = 5;
    localparam int REG_IDX_BITS = 3;
    localparam int DATA_BITS    = 32;

    localparam logic [REG_IDX_BITS-1:0] REG_CLEARANCE   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_ANGLE_START = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_ANGLE_STEP  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_MOVE_COUNT  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_MOVE_DIST0  = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_MOVE_DIST1  = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_MOVE_DIST2  = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_MOVE_DIST3  = 3'd7;

    localparam longint ONE_Q30 = 64'sd1 <<< 30;
    localparam longint PA1 = 1686629713;
    localparam longint PA3 = 693598666;
    localparam longint PA5 = 85569306;
    localparam longint PA7 = 5026994;

    typedef logic [MAG_BITS-1:0] mag_t;
    typedef mag_t [QUARTER-1:0] qrom_t;

    typedef struct packed {
        logic neg;
        mag_t mag;
    } trig_t;

    typedef struct packed {
        logic [CFG_BITS-1:0]                  clearance_mm;
        logic [CFG_BITS-1:0]                  angle_start;
        logic [CFG_BITS-1:0]                  angle_step;
        logic [COUNT_BITS-1:0]                move_count;
        logic [MOVE_REGS-1:0][CFG_BITS-1:0]   move_dist;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_BITS-1:0] range;
        logic                  finite;
        logic                  last;
        logic                  cos_neg;
        mag_t                  sin_mag;
        mag_t                  cos_mag;
    } sample_t;

    function automatic longint mul_q30(longint a, longint b);
        return (a * b) / ONE_Q30;
    endfunction

    // Quarter-wave sine from an odd degree-7 polynomial, t in Q30, result in Q14.
    function automatic mag_t quarter_sine(longint t);
        longint t2;
        longint acc;
        longint s;
        longint q;
        t2  = mul_q30(t, t);
        acc = mul_q30(-PA7, t2) + PA5;
        acc = mul_q30(acc, t2) - PA3;
        acc = mul_q30(acc, t2) + PA1;
        s   = mul_q30(acc, t);
        if (s < 0) begin
            s = 0;
        end
        q = (s + 32768) / 65536;
        if (q > 16384) begin
            q = 16384;
        end
        return q[MAG_BITS-1:0];
    endfunction

    function automatic qrom_t build_qrom();
        qrom_t rom;
        for (int r = 0; r < QUARTER; r++) begin
            rom[r] = quarter_sine((longint'(r) <<< 30) / QUARTER);
        end
        return rom;
    endfunction

    localparam qrom_t QROM = build_qrom();
    // The peak of the wave sits one entry past the quarter table.
    localparam mag_t  QEND = quarter_sine(ONE_Q30);

    function automatic trig_t sine_lookup(logic [IDX_BITS-1:0] idx);
        logic [1:0]          quad;
        logic [QTR_BITS-1:0] rem;
        logic [QTR_BITS-1:0] mir;
        trig_t               res;
        quad = idx[IDX_BITS-1 -: 2];
        rem  = idx[QTR_BITS-1:0];
        mir  = ~rem + 1'b1;
        res.neg = quad[1];
        if (quad[0]) begin
            res.mag = (rem == '0) ? QEND : QROM[mir];
        end else begin
            res.mag = QROM[rem];
        end
        return res;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] scale_angle(logic [CFG_BITS-1:0] v);
        logic [CFG_BITS+ANGLE_BITS-1:0] w;
        w = {v, {ANGLE_BITS{1'b0}}};
        return w[CFG_BITS+ANGLE_BITS-1:CFG_BITS];
    endfunction

endpackage

[rtl/core/scov_front.sv]
`timescale 1ns / 1ps
module scov_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [15:0]                     s_range_mm,
    input  logic                            s_range_finite,
    input  logic                            s_scan_last,
    input  scov_pkg::cfg_t                  cfg,
    input  logic [scov_pkg::QLVL_BITS-1:0]  q_level,
    output logic                            q_push,
    output scov_pkg::sample_t               q_item
);
    import scov_pkg::*;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic                  f_valid_reg, f_valid_next;
    sample_t               f_item_reg, f_item_next;
    logic [ANGLE_BITS-1:0] beam_angle_reg, beam_angle_next;
    logic                  in_scan_reg, in_scan_next;
    logic [ANGLE_BITS-1:0] cur_angle, cos_angle;
    trig_t                 sin_val, cos_val;
    logic                  accept;

    // Room is counted for the sample already held here as well as the new one.
    assign s_ready = ({1'b0, q_level} + {{QLVL_BITS{1'b0}}, f_valid_reg})
                     < (QLVL_BITS + 1)'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    assign cur_angle = in_scan_reg ? beam_angle_reg : scale_angle(cfg.angle_start);
    assign cos_angle = cur_angle + QUARTER_TURN;
    assign sin_val   = sine_lookup(cur_angle[ANGLE_BITS-1 -: IDX_BITS]);
    assign cos_val   = sine_lookup(cos_angle[ANGLE_BITS-1 -: IDX_BITS]);

    always_comb begin
        f_valid_next    = accept;
        f_item_next     = f_item_reg;
        beam_angle_next = beam_angle_reg;
        in_scan_next    = in_scan_reg;
        if (accept) begin
            f_item_next.range   = s_range_mm[RANGE_BITS-1:0];
            f_item_next.finite  = s_range_finite;
            f_item_next.last    = s_scan_last;
            f_item_next.cos_neg = cos_val.neg;
            f_item_next.sin_mag = sin_val.mag;
            f_item_next.cos_mag = cos_val.mag;
            beam_angle_next     = cur_angle + scale_angle(cfg.angle_step);
            in_scan_next        = !s_scan_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg    <= 1'b0;
            beam_angle_reg <= '0;
            in_scan_reg    <= 1'b0;
        end else begin
            f_valid_reg    <= f_valid_next;
            beam_angle_reg <= beam_angle_next;
            in_scan_reg    <= in_scan_next;
        end
        f_item_reg <= f_item_next;
    end

    assign q_push = f_valid_reg;
    assign q_item = f_item_reg;

endmodule

[rtl/core/scov_queue.sv]
`timescale 1ns / 1ps
module scov_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  scov_pkg::sample_t               push_item,
    input  logic                            pop,
    output scov_pkg::sample_t               pop_item,
    output logic [scov_pkg::QLVL_BITS-1:0]  level,
    output logic                            empty
);
    import scov_pkg::*;

    sample_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QLVL_BITS-1:0]  level_reg, level_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = mem_reg[rd_ptr_reg];
    assign level    = level_reg;
    assign empty    = (level_reg == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && level_reg == QLVL_BITS'(QUEUE_DEPTH)))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && level_reg == '0))
        else $error("queue read while empty");
    a_level_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (level_reg == $past(level_reg) + 1'b1))
        else $error("queue level did not follow a lone write");
`endif

endmodule

[rtl/core/scov_back.sv]
`timescale 1ns / 1ps
module scov_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  scov_pkg::cfg_t                  cfg,
    input  logic                            q_empty,
    input  scov_pkg::sample_t               q_item,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [3:0]                      m_veto_mask,
    output logic [15:0]                     m_nearest_mm,
    output logic                            m_obstacle_seen
);
    import scov_pkg::*;

    localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (FRAC_BITS - 1);

    logic advance;

    // Projection stage.
    logic                 b1_valid_reg;
    logic [PROD_BITS-1:0] b1_fwd_reg, b1_lat_reg;
    logic                 b1_fpos_reg, b1_finite_reg, b1_last_reg;

    // Running minimum over the scan and the captured end-of-scan values.
    logic [MM_BITS-1:0]   nearest_reg, nearest_next;
    logic                 found_reg, found_next;
    logic                 res_valid_reg, res_valid_next;
    logic [MM_BITS-1:0]   res_nearest_reg, res_nearest_next;
    logic                 res_found_reg, res_found_next;

    logic [PROD_BITS-1:0] lat_limit;
    logic [PROD_BITS:0]   rounded;
    logic [RND_BITS-1:0]  mm_wide;
    logic [MM_BITS-1:0]   mm;
    logic                 hit;
    logic [MM_BITS-1:0]   near_upd;
    logic                 found_upd;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic [MOVE_REGS-1:0] m_veto_reg, m_veto_next;
    logic [MM_BITS-1:0]   m_nearest_reg, m_nearest_next;
    logic                 m_found_reg, m_found_next;

    // The whole back end holds only while a finished result is refused.
    assign advance = !(m_valid_reg && !m_ready);
    assign q_pop   = !q_empty && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (advance) begin
            b1_valid_reg <= q_pop;
        end
        if (q_pop) begin
            b1_fwd_reg    <= PROD_BITS'(q_item.range) * PROD_BITS'(q_item.cos_mag);
            b1_lat_reg    <= PROD_BITS'(q_item.range) * PROD_BITS'(q_item.sin_mag);
            b1_fpos_reg   <= !q_item.cos_neg;
            b1_finite_reg <= q_item.finite;
            b1_last_reg   <= q_item.last;
        end
    end

    assign lat_limit = {{(PROD_BITS - CFG_BITS - FRAC_BITS){1'b0}}, cfg.clearance_mm,
                        {FRAC_BITS{1'b0}}};
    assign rounded   = {1'b0, b1_fwd_reg} + ROUND_HALF;
    assign mm_wide   = rounded[PROD_BITS:FRAC_BITS];
    assign mm        = (|mm_wide[RND_BITS-1:MM_BITS]) ? {MM_BITS{1'b1}} : mm_wide[MM_BITS-1:0];
    assign hit       = b1_finite_reg && b1_fpos_reg && (b1_fwd_reg != '0)
                       && (b1_lat_reg <= lat_limit);
    assign near_upd  = (hit && (mm < nearest_reg)) ? mm : nearest_reg;
    assign found_upd = found_reg || hit;

    always_comb begin
        nearest_next     = nearest_reg;
        found_next       = found_reg;
        res_valid_next   = res_valid_reg;
        res_nearest_next = res_nearest_reg;
        res_found_next   = res_found_reg;
        if (advance) begin
            res_valid_next = 1'b0;
            if (b1_valid_reg) begin
                if (b1_last_reg) begin
                    res_valid_next   = 1'b1;
                    res_nearest_next = near_upd;
                    res_found_next   = found_upd;
                    nearest_next     = {MM_BITS{1'b1}};
                    found_next       = 1'b0;
                end else begin
                    nearest_next = near_upd;
                    found_next   = found_upd;
                end
            end
        end
    end

    always_comb begin
        logic [CFG_BITS:0] reach;
        logic              en;
        reach          = '0;
        en             = 1'b0;
        m_valid_next   = m_valid_reg;
        m_veto_next    = m_veto_reg;
        m_nearest_next = m_nearest_reg;
        m_found_next   = m_found_reg;
        if (advance) begin
            m_valid_next = res_valid_reg;
            if (res_valid_reg) begin
                m_nearest_next = res_nearest_reg;
                m_found_next   = res_found_reg;
                for (int i = 0; i < MOVE_REGS; i++) begin
                    en    = (i < NUM_MOVES) && (COUNT_BITS'(i) < cfg.move_count);
                    reach = {1'b0, cfg.move_dist[i]} + {1'b0, cfg.clearance_mm};
                    m_veto_next[i] = res_found_reg && en && (reach >= {1'b0, res_nearest_reg});
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nearest_reg   <= {MM_BITS{1'b1}};
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            nearest_reg   <= nearest_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        res_nearest_reg <= res_nearest_next;
        res_found_reg   <= res_found_next;
        m_veto_reg      <= m_veto_next;
        m_nearest_reg   <= m_nearest_next;
        m_found_reg     <= m_found_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_veto_mask     = m_veto_reg;
    assign m_nearest_mm    = m_nearest_reg;
    assign m_obstacle_seen = m_found_reg;

`ifndef SYNTHESIS
    a_empty_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_veto_reg == '0 && m_nearest_reg == '1))
        else $error("scan without obstacle reports a distance or a veto");
    a_veto_needs_obstacle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_veto_reg != '0) |-> m_found_reg)
        else $error("veto raised without an obstacle");
    a_result_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !(b1_valid_reg && b1_last_reg)) |=> !res_valid_reg)
        else $error("end-of-scan result raised without a last sample");
`endif

endmodule

[rtl/core/scan_corridor_obstacle_veto.sv]
`timescale 1ns / 1ps
// A result follows the last sample through the front, queue, projection and result stages.
// Throughput: one sample per cycle; the projection multipliers, the running minimum and the
// sample queue are all fully pipelined, and only a refused result stalls the back end.
// Reset (aresetn, synchronous, active low) returns the registers to their defaults,
// empties the queue and pipeline and starts a fresh scan; no clearing pass is needed.
module scan_corridor_obstacle_veto (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [scov_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [scov_pkg::DATA_BITS-1:0]     pwdata,
    output logic [scov_pkg::DATA_BITS-1:0]     prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [15:0]                        s_range_mm,
    input  logic                               s_range_finite,
    input  logic                               s_scan_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [3:0]                         m_veto_mask,
    output logic [15:0]                        m_nearest_mm,
    output logic                               m_obstacle_seen
);
    import scov_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                  wr_en;
    logic                  q_push, q_pop, q_empty;
    sample_t               q_in_item, q_out_item;
    logic [QLVL_BITS-1:0]  q_level;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_CLEARANCE:   cfg_next.clearance_mm = pwdata[CFG_BITS-1:0];
                REG_ANGLE_START: cfg_next.angle_start  = pwdata[CFG_BITS-1:0];
                REG_ANGLE_STEP:  cfg_next.angle_step   = pwdata[CFG_BITS-1:0];
                REG_MOVE_COUNT:  cfg_next.move_count   = pwdata[COUNT_BITS-1:0];
                REG_MOVE_DIST0:  cfg_next.move_dist[0] = pwdata[CFG_BITS-1:0];
                REG_MOVE_DIST1:  cfg_next.move_dist[1] = pwdata[CFG_BITS-1:0];
                REG_MOVE_DIST2:  cfg_next.move_dist[2] = pwdata[CFG_BITS-1:0];
                REG_MOVE_DIST3:  cfg_next.move_dist[3] = pwdata[CFG_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CLEARANCE:   prdata = DATA_BITS'(cfg_reg.clearance_mm);
            REG_ANGLE_START: prdata = DATA_BITS'(cfg_reg.angle_start);
            REG_ANGLE_STEP:  prdata = DATA_BITS'(cfg_reg.angle_step);
            REG_MOVE_COUNT:  prdata = DATA_BITS'(cfg_reg.move_count);
            REG_MOVE_DIST0:  prdata = DATA_BITS'(cfg_reg.move_dist[0]);
            REG_MOVE_DIST1:  prdata = DATA_BITS'(cfg_reg.move_dist[1]);
            REG_MOVE_DIST2:  prdata = DATA_BITS'(cfg_reg.move_dist[2]);
            REG_MOVE_DIST3:  prdata = DATA_BITS'(cfg_reg.move_dist[3]);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clearance_mm <= '0;
            cfg_reg.angle_start  <= '0;
            cfg_reg.angle_step   <= '0;
            cfg_reg.move_count   <= COUNT_BITS'(1);
            for (int i = 0; i < MOVE_REGS; i++) begin
                cfg_reg.move_dist[i] <= CFG_BITS'(1);
            end
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    scov_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_range_mm     (s_range_mm),
        .s_range_finite (s_range_finite),
        .s_scan_last    (s_scan_last),
        .cfg            (cfg_reg),
        .q_level        (q_level),
        .q_push         (q_push),
        .q_item         (q_in_item)
    );

    scov_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .level     (q_level),
        .empty     (q_empty)
    );

    scov_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_empty         (q_empty),
        .q_item          (q_out_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_veto_mask     (m_veto_mask),
        .m_nearest_mm    (m_nearest_mm),
        .m_obstacle_seen (m_obstacle_seen)
    );

endmodule
